### hdl/msp_pkg.sv
// Package for the multi-servo slew positioner: types, codes and constants.
// Used by msp_cell, msp_pulse_map and multi_servo_slew_positioner; depends on nothing.
`default_nettype none

package msp_pkg;

    localparam int MAX_SERVOS_DEF = 8;
    localparam int SLOT_CAP       = 8;

    localparam logic [7:0] UPPER_RESET   = 8'd180;
    localparam logic [3:0] IN_USE_RESET  = 4'd8;
    localparam logic [7:0] STEP_RESET    = 8'd16;
    localparam logic [11:0] PMIN_RESET   = 12'd500;
    localparam logic [11:0] PMAX_RESET   = 12'd2500;

    // Pulse = (pos * (max - min) + PULSE_SPAN * min) / PULSE_SPAN, with
    // PULSE_SPAN = 180 * 16 = 64 * 45. The divide by 45 is a reciprocal multiply.
    localparam logic [11:0] PULSE_SPAN  = 12'd2880;
    localparam int          SPAN_SHIFT  = 6;
    localparam logic [19:0] RECIP_45    = 20'd745655;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [12:0] PULSE_SAT   = 13'h1FFF;
    localparam logic [11:0] POS_SAT     = 12'hFFF;

    typedef enum logic [1:0] {
        MODE_CONFIG = 2'd0,
        MODE_SET    = 2'd1,
        MODE_BIAS   = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_IN_USE = 2'd0,
        CFG_STEP   = 2'd1,
        CFG_PMIN   = 2'd2,
        CFG_PMAX   = 2'd3
    } cfg_idx_t;

    // One tick result as it travels down the cell chain and the mapper.
    typedef struct packed {
        logic        valid;
        logic        moved;
        logic        last;
        logic [2:0]  idx;
        logic [11:0] pos;
    } rec_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic        load_servo;
        logic        set_target;
        logic        bias_target;
        logic        tick;
        logic        shift;
        logic [2:0]  index;
        logic [7:0]  angle;
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
        logic [7:0]  bias;
        logic [7:0]  step;
        logic [3:0]  count;
    } cell_cmd_t;

endpackage

`default_nettype wire

### hdl/msp_cell.sv
// One servo cell: limits, target and position of one servo, plus a result slot
// that shifts toward the chain head. Depends on msp_pkg.
`default_nettype none

module msp_cell
    import msp_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire rec_t      rec_in,
    output rec_t           rec_out
);

    logic [7:0]  lower_reg,  lower_next;
    logic [7:0]  upper_reg,  upper_next;
    logic [7:0]  target_reg, target_next;
    logic [11:0] pos_reg,    pos_next;
    rec_t        rec_reg,    rec_next;

    logic              hit;
    logic              active;
    logic [12:0]       init_pos;
    logic [7:0]        set_val;
    logic signed [9:0] biased;
    logic signed [9:0] biased_lo;
    logic signed [12:0] delta;
    logic signed [12:0] step_s;
    logic              step_ok;
    logic [11:0]       stepped;

    assign hit    = (cmd.index == 3'(CELL_IDX));
    assign active = (4'(CELL_IDX) < cmd.count);

    always_comb
    begin
        init_pos = {({1'b0, cmd.angle} + 9'd1), 4'b0000};

        set_val = cmd.angle;
        if (set_val < lower_reg)
        begin
            set_val = lower_reg;
        end
        if (set_val > upper_reg)
        begin
            set_val = upper_reg;
        end

        biased = $signed({2'b00, target_reg}) + $signed({{2{cmd.bias[7]}}, cmd.bias});
        biased_lo = biased;
        if (biased_lo < $signed({2'b00, lower_reg}))
        begin
            biased_lo = $signed({2'b00, lower_reg});
        end
        if (biased_lo > $signed({2'b00, upper_reg}))
        begin
            biased_lo = $signed({2'b00, upper_reg});
        end

        delta   = $signed({1'b0, target_reg, 4'b0000}) - $signed({1'b0, pos_reg});
        step_s  = $signed({5'b00000, cmd.step});
        step_ok = (delta >= step_s) || (delta <= -step_s);
        // The step never leaves 0..4095: it stops at or short of the target.
        stepped = (delta > 13'sd0) ? (pos_reg + {4'b0000, cmd.step})
                                   : (pos_reg - {4'b0000, cmd.step});
    end

    always_comb
    begin
        lower_next  = lower_reg;
        upper_next  = upper_reg;
        target_next = target_reg;
        pos_next    = pos_reg;
        rec_next    = rec_reg;

        if (cmd.load_servo && hit)
        begin
            lower_next  = cmd.min_angle;
            upper_next  = cmd.max_angle;
            target_next = cmd.angle;
            pos_next    = init_pos[12] ? POS_SAT : init_pos[11:0];
        end
        if (cmd.set_target && hit && active)
        begin
            target_next = set_val;
        end
        if (cmd.bias_target && hit && active)
        begin
            target_next = biased_lo[7:0];
        end

        if (cmd.tick)
        begin
            if (active && step_ok)
            begin
                pos_next = stepped;
            end
            rec_next.valid = active;
            rec_next.moved = step_ok;
            rec_next.last  = (4'(CELL_IDX + 1) == cmd.count);
            rec_next.idx   = 3'(CELL_IDX);
            rec_next.pos   = step_ok ? stepped : pos_reg;
        end
        else if (cmd.shift)
        begin
            rec_next = rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= '0;
            upper_reg  <= UPPER_RESET;
            target_reg <= '0;
            pos_reg    <= '0;
            rec_reg    <= '0;
        end
        else
        begin
            lower_reg  <= lower_next;
            upper_reg  <= upper_next;
            target_reg <= target_next;
            pos_reg    <= pos_next;
            rec_reg    <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

`default_nettype wire

### hdl/msp_pulse_map.sv
// Shared pulse-width mapper at the head of the cell chain, with the result register.
// Three pipeline stages: span multiply, offset and scale, reciprocal multiply. Depends on msp_pkg.
`default_nettype none

module msp_pulse_map
    import msp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire rec_t        head,
    input  wire logic [11:0] pulse_min,
    input  wire logic [11:0] pulse_max,
    output logic             busy,
    output rec_t             res_info,
    output logic [12:0]      res_pulse
);

    rec_t               s1_reg,  s1_next;
    logic signed [25:0] prod_reg, prod_next;
    rec_t               s2_reg,  s2_next;
    logic [18:0]        x_reg,   x_next;
    rec_t               s3_reg,  s3_next;
    logic [38:0]        y_reg,   y_next;
    rec_t               out_reg, out_next;
    logic [12:0]        pulse_reg, pulse_next;

    logic signed [12:0] span;
    logic [23:0]        base;
    logic signed [26:0] num;
    logic [13:0]        quot;

    always_comb
    begin
        span      = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
        prod_next = $signed({1'b0, head.pos}) * span;

        base   = {12'd0, PULSE_SPAN} * {12'd0, pulse_min};
        num    = 27'(prod_reg) + $signed({3'b000, base});
        x_next = num[26] ? '0 : num[SPAN_SHIFT +: 19];

        y_next = {20'd0, x_reg} * {19'd0, RECIP_45};

        quot       = y_reg[RECIP_SHIFT +: 14];
        pulse_next = (quot > {1'b0, PULSE_SAT}) ? PULSE_SAT : quot[12:0];

        s1_next  = head;
        s2_next  = s1_reg;
        s3_next  = s2_reg;
        out_next = s3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            out_reg <= '0;
        end
        else if (advance)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= prod_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            pulse_reg <= pulse_next;
        end
    end

    assign busy      = s1_reg.valid || s2_reg.valid || s3_reg.valid;
    assign res_info  = out_reg;
    assign res_pulse = pulse_reg;

endmodule

`default_nettype wire

### hdl/multi_servo_slew_positioner.sv
// Top level of the multi-servo slew positioner: configuration registers, command
// decode, the chain of servo cells and the pulse mapper. Depends on msp_pkg,
// msp_cell and msp_pulse_map.
//
// Commands that configure a servo, set or bias its target write the addressed
// cell's registers; set and bias act only on a servo in use. A tick updates every
// servo in use at once, then its results leave the cell chain one per cycle while
// result_stall is low, through the shared pulse mapper: each passes from the head
// cell's result slot through the mapper stages into the result register. No new
// item is taken until the last result of a tick has been delivered.
`default_nettype none

module multi_servo_slew_positioner
    import msp_pkg::*;
#(
    parameter int MAX_SERVOS = MAX_SERVOS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [2:0]  servo_index,
    input  wire logic [7:0]  angle_value,
    input  wire logic [7:0]  min_angle,
    input  wire logic [7:0]  max_angle,
    input  wire logic signed [7:0] bias,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       out_servo,
    output logic             moved,
    output logic [11:0]      current_angle,
    output logic [12:0]      pulse_width,
    output logic             last,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int SLOTS = (MAX_SERVOS < SLOT_CAP) ? MAX_SERVOS : SLOT_CAP;

    logic [3:0]  in_use_reg, in_use_next;
    logic [7:0]  step_reg,   step_next;
    logic [11:0] pmin_reg,   pmin_next;
    logic [11:0] pmax_reg,   pmax_next;

    logic        accept;
    logic        advance;
    logic        map_busy;
    logic [3:0]  count;
    cell_cmd_t   cmd;
    rec_t        chain [SLOTS:0];
    logic [SLOTS-1:0] rec_valid_vec;
    rec_t        res_info;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_use_next = in_use_reg;
        step_next   = step_reg;
        pmin_next   = pmin_reg;
        pmax_next   = pmax_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IN_USE: in_use_next = cfg_data[3:0];
                CFG_STEP:   step_next   = cfg_data[7:0];
                CFG_PMIN:   pmin_next   = cfg_data;
                CFG_PMAX:   pmax_next   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= IN_USE_RESET;
            step_reg   <= STEP_RESET;
            pmin_reg   <= PMIN_RESET;
            pmax_reg   <= PMAX_RESET;
        end
        else
        begin
            in_use_reg <= in_use_next;
            step_reg   <= step_next;
            pmin_reg   <= pmin_next;
            pmax_reg   <= pmax_next;
        end
    end

    assign count      = (in_use_reg > 4'(SLOTS)) ? 4'(SLOTS) : in_use_reg;
    assign advance    = !(result_valid && result_stall);
    assign item_stall = (|rec_valid_vec) || map_busy || result_valid;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        cmd             = '0;
        cmd.shift       = advance;
        cmd.index       = servo_index;
        cmd.angle       = angle_value;
        cmd.min_angle   = min_angle;
        cmd.max_angle   = max_angle;
        cmd.bias        = bias;
        cmd.step        = step_reg;
        cmd.count       = count;
        if (accept)
        begin
            unique case (mode_t'(mode))
                MODE_CONFIG: cmd.load_servo  = 1'b1;
                MODE_SET:    cmd.set_target  = 1'b1;
                MODE_BIAS:   cmd.bias_target = 1'b1;
                MODE_TICK:   cmd.tick        = 1'b1;
            endcase
        end
    end

    assign chain[SLOTS] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        msp_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .rec_in  (chain[i+1]),
            .rec_out (chain[i])
        );
        assign rec_valid_vec[i] = chain[i].valid;
    end

    msp_pulse_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .head      (chain[0]),
        .pulse_min (pmin_reg),
        .pulse_max (pmax_reg),
        .busy      (map_busy),
        .res_info  (res_info),
        .res_pulse (pulse_width)
    );

    assign result_valid  = res_info.valid;
    assign out_servo     = res_info.idx;
    assign moved         = res_info.moved;
    assign current_angle = res_info.pos;
    assign last          = res_info.last;

    // A tick loads exactly one result slot per servo in use.
    a_tick_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_TICK)) |=> ($countones(rec_valid_vec) == $past(count)))
        else $error("tick loaded a wrong number of result slots");

    // Pending results always sit in a gapless run at the chain head.
    a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, rec_valid_vec} + (SLOTS + 1)'(1)))
        else $error("gap in the result chain");

    // Once the last result of a tick is taken, nothing of that tick remains.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && last) |=> (!(|rec_valid_vec) && !map_busy))
        else $error("results left over after the last one");

endmodule

`default_nettype wire
